// File: rtl/core/scfp_pkg.sv
// Shared constants, types and tables of the serial command frame parser.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps

package scfp_pkg;

	localparam int PAYLOAD_MAX    = 16;
	localparam int FRACTION_BITS  = 16;
	localparam int FRAC_DIGIT_CAP = 9;
	localparam int TABLE_SIZE     = 10;
	localparam int WORD_LEN       = 8;

	// 10^9 - 1 fits in 30 bits
	localparam int FRAC_W  = 30;
	localparam int FD_W    = 4;
	localparam int CNT_W   = 5;
	localparam int INT_CAP = 1 << (31 - FRACTION_BITS);
	// integer digits saturate at INT_CAP, one step past it stays below INT_CAP * 16
	localparam int INT_W   = 31 - FRACTION_BITS + 4;
	localparam int Q_W     = FRACTION_BITS + 1;
	localparam int NUM_W   = FRAC_W + Q_W;
	localparam int MAG_W   = INT_W + FRACTION_BITS + 1;
	localparam int STEP_W  = $clog2(Q_W + 1);

	localparam logic [7:0] CH_GET      = 8'h47;
	localparam logic [7:0] CH_SET      = 8'h53;
	localparam logic [7:0] SEP_SET     = 8'h5F;
	localparam logic [7:0] SEP_GET     = 8'h3F;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] LOWER_FIRST = 8'h61;
	localparam logic [7:0] LOWER_LAST  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [1:0] KIND_SET     = 2'd0;
	localparam logic [1:0] KIND_GET     = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;
	localparam logic [3:0] IDX_NONE     = 4'd10;

	typedef enum logic [1:0] {PH_IDLE, PH_WORD, PH_SEP, PH_PAYLOAD} parse_phase_t;
	typedef enum logic [1:0] {NUM_SIGN, NUM_INT, NUM_FRAC, NUM_STOP} num_phase_t;
	typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_SUM, BK_HOLD} back_state_t;

	// one completed frame, handed from the front to the back
	typedef struct packed {
		logic [8*WORD_LEN-1:0] word;      // first character in the top byte
		logic                  has_param;
		logic                  sign;
		logic [INT_W-1:0]      int_acc;
		logic [FRAC_W-1:0]     frac_acc;
		logic [FD_W-1:0]       frac_digits;
	} job_t;

	function automatic logic [8*WORD_LEN-1:0] word_entry(input logic [3:0] i);
		logic [8*WORD_LEN-1:0] w;
		case (i)
			4'd0:    w = "SCOPGAIN";
			4'd1:    w = "GCOPGAIN";
			4'd2:    w = "SCOIGAIN";
			4'd3:    w = "GCOIGAIN";
			4'd4:    w = "SCODGAIN";
			4'd5:    w = "GCODGAIN";
			4'd6:    w = "SCONILIM";
			4'd7:    w = "GCONILIM";
			4'd8:    w = "SSTOCONF";
			4'd9:    w = "GCOLOTIM";
			default: w = '0;
		endcase
		return w;
	endfunction

	function automatic logic [FRAC_W-1:0] pow_ten(input logic [FD_W-1:0] n);
		logic [FRAC_W-1:0] p;
		case (n)
			4'd1:    p = FRAC_W'(10);
			4'd2:    p = FRAC_W'(100);
			4'd3:    p = FRAC_W'(1000);
			4'd4:    p = FRAC_W'(10000);
			4'd5:    p = FRAC_W'(100000);
			4'd6:    p = FRAC_W'(1000000);
			4'd7:    p = FRAC_W'(10000000);
			4'd8:    p = FRAC_W'(100000000);
			4'd9:    p = FRAC_W'(1000000000);
			default: p = FRAC_W'(1);
		endcase
		return p;
	endfunction

endpackage

// File: rtl/core/scfp_front.sv
// Front end: folds case, tracks frame phase, collects the command word and
// converts the payload digits on the fly. Depends on scfp_pkg.
`timescale 1ns / 1ps

module scfp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    rx_byte,
	output logic          job_push,
	output scfp_pkg::job_t job
);
	import scfp_pkg::*;

	parse_phase_t      phase_q, phase_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_inc;
	logic [7:0]        word_q [WORD_LEN];
	logic [7:0]        prev_q;
	logic              sign_q, sign_nxt;
	logic [INT_W-1:0]  int_q, int_nxt;
	logic [FRAC_W-1:0] frac_q, frac_nxt;
	logic [FD_W-1:0]   fd_q, fd_nxt;
	num_phase_t        nph_q, nph_nxt;

	logic [7:0] b;
	logic       is_start, sep_ok, crlf, word_full, payload_end, digit;
	logic [3:0] d;

	always_comb begin
		if (rx_byte >= LOWER_FIRST && rx_byte <= LOWER_LAST)
			b = rx_byte - CASE_OFFSET;
		else
			b = rx_byte;
	end

	assign cnt_inc     = cnt_q + CNT_W'(1);
	assign is_start    = (b == CH_GET) || (b == CH_SET);
	assign sep_ok      = (word_q[0] == CH_GET && b == SEP_GET) ||
	                     (word_q[0] == CH_SET && b == SEP_SET);
	assign crlf        = (prev_q == CH_CR) && (b == CH_LF);
	assign word_full   = cnt_inc >= CNT_W'(WORD_LEN);
	assign payload_end = crlf && cnt_inc >= CNT_W'(2);
	assign digit       = (b >= CH_ZERO) && (b <= CH_NINE);
	assign d           = b[3:0];

	// number conversion, one character per transaction
	always_comb begin
		sign_nxt = sign_q;
		int_nxt  = int_q;
		frac_nxt = frac_q;
		fd_nxt   = fd_q;
		nph_nxt  = nph_q;
		if (nph_q == NUM_SIGN && (b == CH_PLUS || b == CH_MINUS)) begin
			sign_nxt = (b == CH_MINUS);
			nph_nxt  = NUM_INT;
		end else if ((nph_q == NUM_SIGN || nph_q == NUM_INT) && digit) begin
			if (int_q >= INT_W'(INT_CAP))
				int_nxt = INT_W'(INT_CAP);
			else
				int_nxt = (int_q << 3) + (int_q << 1) + INT_W'(d);
			nph_nxt = NUM_INT;
		end else if ((nph_q == NUM_SIGN || nph_q == NUM_INT) && b == CH_DOT) begin
			nph_nxt = NUM_FRAC;
		end else if (nph_q == NUM_FRAC && digit) begin
			if (fd_q < FD_W'(FRAC_DIGIT_CAP)) begin
				frac_nxt = (frac_q << 3) + (frac_q << 1) + FRAC_W'(d);
				fd_nxt   = fd_q + FD_W'(1);
			end
		end else begin
			nph_nxt = NUM_STOP;
		end
	end

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		if (in_valid) begin
			case (phase_q)
				PH_IDLE:    if (is_start) phase_nxt = PH_WORD;
				PH_WORD:    if (word_full) phase_nxt = PH_SEP;
				PH_SEP:     phase_nxt = sep_ok ? PH_PAYLOAD : PH_IDLE;
				PH_PAYLOAD: begin
					if (payload_end || cnt_inc >= CNT_W'(PAYLOAD_MAX))
						phase_nxt = PH_IDLE;
				end
				default:    phase_nxt = PH_IDLE;
			endcase
		end
	end

	// frame hand-off; a bare CR LF only reports for a get frame
	always_comb begin
		job_push        = in_valid && phase_q == PH_PAYLOAD && payload_end &&
		                  (cnt_inc != CNT_W'(2) || word_q[0] == CH_GET);
		job.word        = {word_q[0], word_q[1], word_q[2], word_q[3],
		                   word_q[4], word_q[5], word_q[6], word_q[7]};
		job.has_param   = cnt_inc != CNT_W'(2);
		job.sign        = sign_q;
		job.int_acc     = int_q;
		job.frac_acc    = frac_q;
		job.frac_digits = fd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			for (int i = 0; i < WORD_LEN; i++)
				word_q[i] <= '0;
			prev_q  <= '0;
			sign_q  <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			fd_q    <= '0;
			nph_q   <= NUM_SIGN;
		end else begin
			phase_q <= phase_nxt;
			if (in_valid) begin
				case (phase_q)
					PH_IDLE: begin
						if (is_start) begin
							word_q[0] <= b;
							cnt_q     <= CNT_W'(1);
						end
					end
					PH_WORD: begin
						word_q[cnt_q[2:0]] <= b;
						cnt_q <= word_full ? '0 : cnt_inc;
					end
					PH_SEP: begin
						if (sep_ok) begin
							cnt_q  <= '0;
							prev_q <= '0;
							sign_q <= 1'b0;
							int_q  <= '0;
							frac_q <= '0;
							fd_q   <= '0;
							nph_q  <= NUM_SIGN;
						end
					end
					PH_PAYLOAD: begin
						cnt_q <= cnt_inc;
						if (!payload_end) begin
							prev_q <= b;
							sign_q <= sign_nxt;
							int_q  <= int_nxt;
							frac_q <= frac_nxt;
							fd_q   <= fd_nxt;
							nph_q  <= nph_nxt;
						end
					end
					default: cnt_q <= '0;
				endcase
			end
		end
	end

endmodule

// File: rtl/core/scfp_job_queue.sv
// Two-entry queue of finished frames between front and back.
// Depends on scfp_pkg for the frame record.
`timescale 1ns / 1ps

module scfp_job_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scfp_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output scfp_pkg::job_t head
);
	import scfp_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/core/scfp_frac_div.sv
// Restoring divider, one quotient bit per cycle, for scaling the decimal
// fraction to binary. Depends on scfp_pkg for widths.
`timescale 1ns / 1ps

module scfp_frac_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [scfp_pkg::NUM_W-1:0]   num,
	input  logic [scfp_pkg::FRAC_W-1:0]  den,
	output logic                         busy,
	output logic [scfp_pkg::Q_W-1:0]     quotient
);
	import scfp_pkg::*;

	logic [FRAC_W-1:0] rem_q, den_q;
	logic [Q_W-1:0]    low_q, quo_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [FRAC_W:0]   trial, diff;
	logic              ge;

	// the top part of the numerator is already below the divisor
	assign trial = {rem_q, low_q[Q_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:Q_W];
			low_q <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
			low_q <= low_q << 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(Q_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1))
				busy_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/scfp_back.sv
// Back end: matches the command word, finishes the fixed-point value with
// saturation and holds the result register. Depends on scfp_pkg, scfp_frac_div.
`timescale 1ns / 1ps

module scfp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_valid,
	input  scfp_pkg::job_t       job,
	output logic                 job_pop,
	output logic                 res_valid,
	input  logic                 res_pop,
	output logic [1:0]           request_kind,
	output logic [3:0]           command_index,
	output logic                 has_parameter,
	output logic signed [31:0]   parameter_value
);
	import scfp_pkg::*;

	back_state_t      st_q, st_nxt;
	logic [3:0]       idx_q, match_idx;
	logic [1:0]       kind_q, match_kind;
	logic             has_q, sign_q;
	logic [INT_W-1:0] int_q;
	logic [MAG_W-1:0] mag_q;
	logic [31:0]      sat_val;

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic [3:0]       out_idx_q;
	logic             out_has_q;
	logic [31:0]      out_val_q;

	logic              div_start, div_busy, load;
	logic [FRAC_W-1:0] den;
	logic [NUM_W-1:0]  num;
	logic [Q_W-1:0]    quo;

	// first table entry that matches wins
	always_comb begin
		match_idx  = IDX_NONE;
		match_kind = KIND_UNKNOWN;
		for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
			if (job.word == word_entry(4'(i))) begin
				match_idx  = 4'(i);
				match_kind = (word_entry(4'(i)) >> (8 * (WORD_LEN - 1))) == 64'(CH_GET)
				             ? KIND_GET : KIND_SET;
			end
		end
	end

	// (frac << FRACTION_BITS) + den / 2, rounds half up
	assign den = pow_ten(job.frac_digits);
	assign num = (NUM_W'(job.frac_acc) << FRACTION_BITS) + NUM_W'(den >> 1);

	scfp_frac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num),
		.den      (den),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			BK_IDLE: if (job_valid) st_nxt = job.has_param ? BK_DIV : BK_HOLD;
			BK_DIV:  if (!div_busy) st_nxt = BK_SUM;
			BK_SUM:  st_nxt = BK_HOLD;
			BK_HOLD: if (load) st_nxt = BK_IDLE;
			default: st_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		job_pop   = 1'b0;
		div_start = 1'b0;
		load      = 1'b0;
		case (st_q)
			BK_IDLE: begin
				job_pop   = job_valid;
				div_start = job_valid && job.has_param;
			end
			BK_HOLD: load = !out_valid_q || res_pop;
			default: ;
		endcase
	end

	always_comb begin
		if (sign_q)
			sat_val = (mag_q[MAG_W-1:31] != '0) ? 32'h8000_0000 : 32'(-mag_q[31:0]);
		else
			sat_val = (mag_q[MAG_W-1:31] != '0) ? 32'h7FFF_FFFF : mag_q[31:0];
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			idx_q  <= match_idx;
			kind_q <= match_kind;
			has_q  <= job.has_param;
			sign_q <= job.sign;
			int_q  <= job.int_acc;
		end
		if (st_q == BK_SUM)
			mag_q <= (MAG_W'(int_q) << FRACTION_BITS) + MAG_W'(quo);
		if (load) begin
			out_kind_q <= kind_q;
			out_idx_q  <= idx_q;
			out_has_q  <= has_q;
			out_val_q  <= has_q ? sat_val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (load)
				out_valid_q <= 1'b1;
			else if (res_pop)
				out_valid_q <= 1'b0;
		end
	end

	assign res_valid       = out_valid_q;
	assign request_kind    = out_kind_q;
	assign command_index   = out_idx_q;
	assign has_parameter   = out_has_q;
	assign parameter_value = out_val_q;

endmodule

// File: rtl/core/serial_command_frame_parser.sv
// Serial command frame parser, top level.
// Input side: push a received byte while full is low; it is taken at that edge.
// Result side: while empty is low the oldest result sits on request_kind,
//   command_index, has_parameter and parameter_value; pop with empty low
//   takes it.
// Bytes are taken one per cycle while full is low. The front end turns the
// byte that ends a frame (the LF of CR LF) into a frame record in the same
// cycle; the back end carries it from there to the result register through
// a capture step, the bit-serial fraction divider, a step to see it finish,
// a sum step and a load, while a bare get frame skips the divider.
// The divider limits the sustained rate of frames with a payload: the back
// end takes a new frame only after the last one is loaded. A two-entry
// frame queue sits between front and back, so full only rises when two
// frames wait there.
// Reset (arst_n low) returns the parser to idle and drops all queued frames
// and any waiting result. A stalled receiver holds the result register; the
// back end then waits and the queue fills, after which full holds off input.
// Depends on scfp_pkg, scfp_front, scfp_job_queue, scfp_back.
`timescale 1ns / 1ps

module serial_command_frame_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [7:0]          rx_byte,
	output logic                empty,
	input  logic                pop,
	output logic [1:0]          request_kind,
	output logic [3:0]          command_index,
	output logic                has_parameter,
	output logic signed [31:0]  parameter_value
);
	import scfp_pkg::*;

	job_t front_job, head_job;
	logic front_push, q_full, q_empty, q_pop, res_valid;

	scfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push && !q_full),
		.rx_byte  (rx_byte),
		.job_push (front_push),
		.job      (front_job)
	);

	scfp_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.push_job (front_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	scfp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (!q_empty),
		.job             (head_job),
		.job_pop         (q_pop),
		.res_valid       (res_valid),
		.res_pop         (pop),
		.request_kind    (request_kind),
		.command_index   (command_index),
		.has_parameter   (has_parameter),
		.parameter_value (parameter_value)
	);

	assign full  = q_full;
	assign empty = !res_valid;

endmodule

// File: tb/serial_command_frame_parser_tb.sv
// Self-checking testbench for serial_command_frame_parser: directed frames from a table,
// then random frames, with a byte-level frame predictor and random idling on both queues.
// Depends on scfp_pkg and serial_command_frame_parser.
`timescale 1ns / 1ps

module serial_command_frame_parser_tb;
	import scfp_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int BYTE_TARGET = 1300;
	localparam int DRAIN_CYCLES = 40;

	localparam logic [63:0] COMMAND_WORDS [TABLE_SIZE] = '{
		"SCOPGAIN", "GCOPGAIN", "SCOIGAIN", "GCOIGAIN", "SCODGAIN",
		"GCODGAIN", "SCONILIM", "GCONILIM", "SSTOCONF", "GCOLOTIM"
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  entry;
		logic        has_value;
		logic [31:0] value;
	} frame_result_t;

	typedef enum {ROW_PREDICT, ROW_RESULT, ROW_NONE} row_check_t;

	typedef struct {
		string         text;
		row_check_t    mode;
		frame_result_t res;
	} directed_row_t;

	typedef logic [7:0] byte_q_t [$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic pop = 1'b0;
	logic full, empty, has_parameter;
	logic [1:0] request_kind;
	logic [3:0] command_index;
	logic signed [31:0] parameter_value;

	serial_command_frame_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.rx_byte         (rx_byte),
		.empty           (empty),
		.pop             (pop),
		.request_kind    (request_kind),
		.command_index   (command_index),
		.has_parameter   (has_parameter),
		.parameter_value (parameter_value)
	);

	always #2 clk = ~clk;

	// a tilde in a row stands for a NUL byte
	directed_row_t directed_rows [$] = '{
		'{"GCOPGAIN?\015\012", ROW_RESULT, '{KIND_GET, 4'd1, 1'b0, 32'd0}},
		'{"SCOPGAIN_1.5\015\012", ROW_RESULT, '{KIND_SET, 4'd0, 1'b1, 32'h0001_8000}},
		'{"scoigain_-2\015\012", ROW_RESULT, '{KIND_SET, 4'd2, 1'b1, 32'hFFFE_0000}},
		'{"GcoIgain?\015\012", ROW_RESULT, '{KIND_GET, 4'd3, 1'b0, 32'd0}},
		'{"SCODGAIN_0.1\015\012", ROW_PREDICT, '0},
		'{"GCODGAIN?+7\015\012", ROW_RESULT, '{KIND_GET, 4'd5, 1'b1, 32'h0007_0000}},
		'{"SCONILIM_99999\015\012", ROW_RESULT, '{KIND_SET, 4'd6, 1'b1, 32'h7FFF_FFFF}},
		'{"GCONILIM?-99999\015\012", ROW_RESULT, '{KIND_GET, 4'd7, 1'b1, 32'h8000_0000}},
		'{"SSTOCONF_-32768\015\012", ROW_RESULT, '{KIND_SET, 4'd8, 1'b1, 32'h8000_0000}},
		'{"SSTOCONF_32767.99999\015\012", ROW_PREDICT, '0},
		'{"GCOLOTIM?0.123456789123\015\012", ROW_PREDICT, '0},
		'{"SSTOCONF_\015\012", ROW_NONE, '0},
		'{"GABCDEFG?5\015\012", ROW_RESULT, '{KIND_UNKNOWN, IDX_NONE, 1'b1, 32'h0005_0000}},
		'{"SCOPGAIN?1\015\012", ROW_NONE, '0},
		'{"GCOPGAIN? 5\015\012", ROW_RESULT, '{KIND_GET, 4'd1, 1'b1, 32'd0}},
		'{"GCOPGAIN?1e5\015\012", ROW_RESULT, '{KIND_GET, 4'd1, 1'b1, 32'h0001_0000}},
		'{"SCOPGAIN_inf\015\012", ROW_RESULT, '{KIND_SET, 4'd0, 1'b1, 32'd0}},
		'{"SCOPGAIN_123456789012345678\015\012", ROW_NONE, '0},
		'{"G~COPGAI?3\015\012", ROW_RESULT, '{KIND_UNKNOWN, IDX_NONE, 1'b1, 32'h0003_0000}},
		'{"GCOPGAIN?\015X\015\012", ROW_RESULT, '{KIND_GET, 4'd1, 1'b1, 32'd0}},
		'{"SCOPGAIN_.5\015\012", ROW_RESULT, '{KIND_SET, 4'd0, 1'b1, 32'h0000_8000}},
		'{"SCOPGAIN_+-3\015\012", ROW_RESULT, '{KIND_SET, 4'd0, 1'b1, 32'd0}},
		// wrong separator is swallowed, the rest leaves a stray word that '!' discards
		'{"GCOPGAINSCOPGAIN_1\015\012!", ROW_NONE, '0},
		'{"\377~GCOPGAIN?\377\015\012", ROW_RESULT, '{KIND_GET, 4'd1, 1'b1, 32'd0}},
		'{"`scopgain_1{\015\012", ROW_RESULT, '{KIND_SET, 4'd0, 1'b1, 32'h0001_0000}}
	};

	// predictor state
	parse_phase_t frame_phase = PH_IDLE;
	num_phase_t num_phase = NUM_SIGN;
	logic [4:0] byte_count = '0;
	logic [63:0] cmd_word = '0;
	logic [7:0] last_payload = '0;
	logic negative = 1'b0;
	logic [31:0] int_acc = '0;
	logic [31:0] frac_acc = '0;
	logic [3:0] frac_digits = '0;

	frame_result_t pending_results [$];
	int errors = 0;
	int bytes_sent = 0;
	int results_planned = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int idle_cycles = 0;
	bit hold_request = 1'b0;
	logic results_held = 1'b0;

	function automatic frame_result_t frame_result(input bit with_value);
		frame_result_t r;
		logic [63:0] den, fq, mag;
		r = '{KIND_UNKNOWN, IDX_NONE, with_value, 32'd0};
		for (int i = 0; i < TABLE_SIZE; i++)
			if (r.entry == IDX_NONE && cmd_word == COMMAND_WORDS[i]) begin
				r.entry = 4'(i);
				r.kind = (COMMAND_WORDS[i][63:56] == CH_GET) ? KIND_GET : KIND_SET;
			end
		if (with_value) begin
			den = 64'd1;
			for (int k = 0; k < frac_digits; k++)
				den = den * 10;
			fq = (({32'd0, frac_acc} << FRACTION_BITS) + (den >> 1)) / den;
			mag = ({32'd0, int_acc} << FRACTION_BITS) + fq;
			if (negative)
				r.value = (mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
			else
				r.value = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
		return r;
	endfunction

	function automatic void parse_byte(input logic [7:0] rx, output bit made,
			output frame_result_t r);
		logic [7:0] c;
		bit digit;
		c = rx;
		made = 1'b0;
		r = '0;
		if (c >= LOWER_FIRST && c <= LOWER_LAST)
			c = c - CASE_OFFSET;
		case (frame_phase)
			PH_IDLE: if (c == CH_GET || c == CH_SET) begin
				cmd_word[63:56] = c;
				byte_count = 5'd1;
				frame_phase = PH_WORD;
			end
			PH_WORD: begin
				cmd_word[63 - 8 * byte_count[2:0] -: 8] = c;
				byte_count++;
				if (byte_count >= WORD_LEN) begin
					byte_count = '0;
					frame_phase = PH_SEP;
				end
			end
			PH_SEP: if ((cmd_word[63:56] == CH_GET && c == SEP_GET) ||
					(cmd_word[63:56] == CH_SET && c == SEP_SET)) begin
				frame_phase = PH_PAYLOAD;
				byte_count = '0;
				last_payload = '0;
				negative = 1'b0;
				int_acc = '0;
				frac_acc = '0;
				frac_digits = '0;
				num_phase = NUM_SIGN;
			end else begin
				frame_phase = PH_IDLE;
			end
			default: begin
				byte_count++;
				if (byte_count == 5'd2 && last_payload == CH_CR && c == CH_LF) begin
					// bare line end only answers a get
					if (cmd_word[63:56] == CH_GET) begin
						r = frame_result(1'b0);
						made = 1'b1;
					end
					frame_phase = PH_IDLE;
				end else if (byte_count > 5'd2 && last_payload == CH_CR && c == CH_LF) begin
					r = frame_result(1'b1);
					made = 1'b1;
					frame_phase = PH_IDLE;
				end else begin
					digit = (c >= CH_ZERO && c <= CH_NINE);
					if (num_phase == NUM_SIGN && (c == CH_PLUS || c == CH_MINUS)) begin
						negative = (c == CH_MINUS);
						num_phase = NUM_INT;
					end else if ((num_phase == NUM_SIGN || num_phase == NUM_INT) && digit) begin
						if (int_acc >= 32'(INT_CAP))
							int_acc = 32'(INT_CAP);
						else
							int_acc = int_acc * 10 + 32'(c - CH_ZERO);
						num_phase = NUM_INT;
					end else if ((num_phase == NUM_SIGN || num_phase == NUM_INT) &&
							c == CH_DOT) begin
						num_phase = NUM_FRAC;
					end else if (num_phase == NUM_FRAC && digit) begin
						if (frac_digits < FRAC_DIGIT_CAP) begin
							frac_acc = frac_acc * 10 + 32'(c - CH_ZERO);
							frac_digits++;
						end
					end else begin
						num_phase = NUM_STOP;
					end
					last_payload = c;
					if (byte_count >= PAYLOAD_MAX)
						frame_phase = PH_IDLE;
				end
			end
		endcase
	endfunction

	function automatic byte_q_t random_frame();
		byte_q_t f;
		logic [63:0] w;
		logic [7:0] c;
		int pick, n;
		pick = $urandom_range(99);
		if (pick < 12) begin
			// line noise, may open a frame or break one
			n = $urandom_range(1, 20);
			repeat (n) f.push_back(8'($urandom_range(255)));
			return f;
		end
		w = COMMAND_WORDS[$urandom_range(TABLE_SIZE - 1)];
		if (pick < 22)
			for (int k = 1; k < WORD_LEN; k++)
				w[63 - 8 * k -: 8] = 8'($urandom_range(255));
		for (int k = 0; k < WORD_LEN; k++) begin
			c = w[63 - 8 * k -: 8];
			if (c >= "A" && c <= "Z" && $urandom_range(3) == 0)
				c = c + CASE_OFFSET;
			f.push_back(c);
		end
		c = (w[63:56] == CH_GET) ? SEP_GET : SEP_SET;
		f.push_back(($urandom_range(19) == 0) ? 8'($urandom_range(255)) : c);
		if (pick < 28) begin
			n = $urandom_range(1, 18);
			repeat (n) f.push_back(8'($urandom_range(255)));
		end else if (pick >= 36) begin
			case ($urandom_range(3))
				1: f.push_back(CH_PLUS);
				2: f.push_back(CH_MINUS);
				default: ;
			endcase
			n = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 3);
			repeat (n) f.push_back(CH_ZERO + 8'($urandom_range(9)));
			if ($urandom_range(1)) begin
				f.push_back(CH_DOT);
				n = $urandom_range(0, 11);
				repeat (n) f.push_back(CH_ZERO + 8'($urandom_range(9)));
			end
			if ($urandom_range(9) == 0)
				f.insert($urandom_range(9, f.size()), 8'($urandom_range(255)));
		end
		// pick 28..35 leaves a bare line end
		if ($urandom_range(19) != 0) begin
			f.push_back(CH_CR);
			f.push_back(CH_LF);
		end
		return f;
	endfunction

	task automatic send_bytes(input byte_q_t seq, input row_check_t mode,
			input frame_result_t typed_res);
		frame_result_t r;
		bit made;
		foreach (seq[k]) begin
			if ($urandom_range(99) < tx_idle_pct) begin
				push <= 1'b0;
				do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
			end
			push <= 1'b1;
			rx_byte <= seq[k];
			do @(posedge clk); while (full);
			bytes_sent++;
			parse_byte(seq[k], made, r);
			if (k == seq.size() - 1 && mode != ROW_PREDICT) begin
				if (mode == ROW_RESULT) begin
					pending_results.push_back(typed_res);
					results_planned++;
				end
			end else if (made) begin
				pending_results.push_back(r);
				results_planned++;
			end
		end
	endtask

	// result side: check each popped transaction against the oldest pending frame
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result kind %0d index %0d value %0h", $time,
						request_kind, command_index, parameter_value);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (request_kind !== want.kind) begin
						$display("%0t: request_kind expected %0d got %0d", $time,
							want.kind, request_kind);
						errors++;
					end
					if (command_index !== want.entry) begin
						$display("%0t: command_index expected %0d got %0d", $time,
							want.entry, command_index);
						errors++;
					end
					if (has_parameter !== want.has_value) begin
						$display("%0t: has_parameter expected %0d got %0d", $time,
							want.has_value, has_parameter);
						errors++;
					end
					if (parameter_value !== want.value) begin
						$display("%0t: parameter_value expected %h got %h", $time,
							want.value, parameter_value);
						errors++;
					end
				end
			end
			pop <= !results_held && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// long receiver hold-off so the frame queue fills and full stalls input
	initial begin
		wait (hold_request);
		@(posedge clk);
		results_held <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		results_held <= 1'b0;
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		byte_q_t seq;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 28;
		rx_idle_pct = 51;
		foreach (directed_rows[i]) begin
			seq = {};
			for (int k = 0; k < directed_rows[i].text.len(); k++)
				seq.push_back((directed_rows[i].text[k] == "~") ? 8'h00 :
					directed_rows[i].text[k]);
			send_bytes(seq, directed_rows[i].mode, directed_rows[i].res);
		end
		for (int p = 0; p < 3; p++) begin
			// let everything in flight drain before the idling pattern changes
			push <= 1'b0;
			do @(posedge clk); while (pending_results.size() != 0);
			tx_idle_pct = (p == 0) ? 28 : (p == 1) ? 51 : 0;
			rx_idle_pct = (p == 0) ? 51 : (p == 1) ? 28 : 0;
			if (p == 0)
				hold_request = 1'b1;
			while (bytes_sent < BYTE_TARGET * (p + 2) / 4 ||
					(p == 2 && results_planned < 60))
				send_bytes(random_frame(), ROW_PREDICT, '0);
		end
		push <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/scfp_pkg.sv
rtl/core/scfp_front.sv
rtl/core/scfp_job_queue.sv
rtl/core/scfp_frac_div.sv
rtl/core/scfp_back.sv
rtl/core/serial_command_frame_parser.sv
tb/serial_command_frame_parser_tb.sv
